@@ src/rlds_pkg.sv @@
// Shared types, constants and codes of the run-length shape decoder.
package rlds_pkg;

  localparam int MAX_RUN_DEF  = 64;
  localparam int CNT_W        = 7;   // holds a run length up to 64
  localparam int ACC_W        = 40;
  localparam int QUEUE_DEPTH  = 4;
  localparam int PTR_W        = 2;
  localparam int ADDR_W       = 4;

  localparam logic [1:0] REG_PACKED_COUNT = 2'd0;
  localparam logic [1:0] REG_SAMPLE_COUNT = 2'd1;
  localparam logic [1:0] REG_SCALE        = 2'd2;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_FRAC   = 3'd1;
  localparam logic [2:0] ERR_RANGE  = 3'd2;
  localparam logic [2:0] ERR_TRUNC  = 3'd3;
  localparam logic [2:0] ERR_LENGTH = 3'd4;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    JOB_PLAIN = 2'd0,
    JOB_RUN   = 2'd1,
    JOB_ERR   = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [31:0]       val_a;
    logic [CNT_W-1:0]  cnt_a;
    logic              has_b;
    logic [31:0]       val_b;
    logic [15:0]       index;
    logic              shape_end;
    logic [2:0]        err;
  } job_t;

  typedef struct packed {
    logic [15:0]        packed_count;
    logic [15:0]        sample_count;
    logic signed [31:0] scale;
  } cfg_t;

endpackage

@@ src/rlds_fifo.sv @@
// Short job queue between the classifying front end and the sample back end.
module rlds_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rlds_pkg::job_t wdata,
  input  logic          pop,
  output rlds_pkg::job_t rdata,
  output logic          empty,
  output logic          full
);
  import rlds_pkg::*;

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ src/rlds_front.sv @@
// Front end: accepts packed words, tracks run-length state and issues jobs.
module rlds_front #(
  parameter int MAX_RUN = rlds_pkg::MAX_RUN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rlds_pkg::cfg_t cfg,
  input  logic          cfg_clear,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [31:0]   in_word,
  input  logic          q_full,
  output logic          q_push,
  output rlds_pkg::job_t q_job
);
  import rlds_pkg::*;

  localparam logic [7:0] MAX_RUN_B = 8'(MAX_RUN);

  logic [31:0] held_value_r, held_value_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic [15:0] words_seen_r, words_seen_nxt;
  logic [15:0] samples_r, samples_nxt;

  logic        accept;
  logic        last;
  logic        plain;
  logic        same;
  logic [7:0]  rep;
  logic [7:0]  pushes;
  logic [16:0] total;
  logic [2:0]  err;
  logic [15:0] err_idx;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    last  = ({1'b0, words_seen_r} + 17'd1) >= {1'b0, cfg.packed_count};
    plain = (cfg.packed_count == cfg.sample_count);
    same  = held_valid_r && (in_word == held_value_r);
    rep   = {1'b0, in_word[30:24]} + 8'd2;

    pushes  = '0;
    err     = ERR_NONE;
    err_idx = samples_r;
    if (awaiting_r) begin
      if (in_word[23:0] != 24'd0) begin
        err = ERR_FRAC;
      end else if (in_word[31] || (rep > MAX_RUN_B)) begin
        err = ERR_RANGE;
      end else begin
        pushes = rep;
      end
    end else if (same) begin
      if (last) begin
        err = ERR_TRUNC;
      end
    end else begin
      pushes = {7'd0, held_valid_r} + {7'd0, last};
    end

    total = {1'b0, samples_r} + {9'd0, pushes};
    if (err == ERR_NONE) begin
      if (total > {1'b0, cfg.sample_count}) begin
        err     = ERR_LENGTH;
        err_idx = cfg.sample_count;
      end else if (last && (total != {1'b0, cfg.sample_count})) begin
        err     = ERR_LENGTH;
        err_idx = total[15:0];
      end
    end
  end

  always_comb begin
    held_value_nxt = held_value_r;
    held_valid_nxt = held_valid_r;
    awaiting_nxt   = awaiting_r;
    words_seen_nxt = words_seen_r;
    samples_nxt    = samples_r;
    q_push         = 1'b0;
    q_job          = '0;
    q_job.kind     = JOB_PLAIN;
    q_job.err      = ERR_NONE;

    if (accept && (cfg.packed_count != 16'd0)) begin
      if (plain) begin
        q_push          = 1'b1;
        q_job.kind      = JOB_PLAIN;
        q_job.val_a     = in_word;
        q_job.index     = words_seen_r;
        q_job.shape_end = last;
        words_seen_nxt  = last ? 16'd0 : words_seen_r + 16'd1;
      end else begin
        if (err != ERR_NONE) begin
          q_push      = 1'b1;
          q_job.kind  = JOB_ERR;
          q_job.index = err_idx;
          q_job.err   = err;
        end else if (pushes != 8'd0) begin
          q_push          = 1'b1;
          q_job.kind      = JOB_RUN;
          q_job.index     = samples_r;
          q_job.shape_end = last;
          if (awaiting_r) begin
            q_job.val_a = held_value_r;
            q_job.cnt_a = pushes[CNT_W-1:0];
          end else if (held_valid_r) begin
            q_job.val_a = held_value_r;
            q_job.cnt_a = CNT_W'(1);
            q_job.has_b = last;
            q_job.val_b = in_word;
          end else begin
            q_job.val_a = in_word;
            q_job.cnt_a = CNT_W'(1);
          end
        end

        if ((err != ERR_NONE) || last) begin
          held_value_nxt = '0;
          held_valid_nxt = 1'b0;
          awaiting_nxt   = 1'b0;
          words_seen_nxt = '0;
          samples_nxt    = '0;
        end else begin
          words_seen_nxt = words_seen_r + 16'd1;
          samples_nxt    = total[15:0];
          if (awaiting_r) begin
            held_valid_nxt = 1'b0;
            awaiting_nxt   = 1'b0;
          end else if (same) begin
            awaiting_nxt = 1'b1;
          end else begin
            held_value_nxt = in_word;
            held_valid_nxt = 1'b1;
          end
        end
      end
    end

    if (cfg_clear) begin
      held_value_nxt = '0;
      held_valid_nxt = 1'b0;
      awaiting_nxt   = 1'b0;
      words_seen_nxt = '0;
      samples_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_value_r <= '0;
      held_valid_r <= 1'b0;
      awaiting_r   <= 1'b0;
      words_seen_r <= '0;
      samples_r    <= '0;
    end else begin
      held_value_r <= held_value_nxt;
      held_valid_r <= held_valid_nxt;
      awaiting_r   <= awaiting_nxt;
      words_seen_r <= words_seen_nxt;
      samples_r    <= samples_nxt;
    end
  end

endmodule

@@ src/rlds_back.sv @@
// Back end: expands jobs into samples, integrates, scales and drives results.
module rlds_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [31:0] cfg_scale,
  input  logic               cfg_clear,
  input  logic               q_empty,
  input  rlds_pkg::job_t     q_job,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_sample_value,
  output logic [15:0]        out_sample_index,
  output logic               out_run_last,
  output logic               out_shape_done,
  output logic [2:0]         out_error_code
);
  import rlds_pkg::*;

  // sequencer
  logic             busy_r, busy_nxt;
  job_t             job_r, job_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             phase_b_r, phase_b_nxt;
  logic [15:0]      idx_r, idx_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;

  // stage A: integrated sample
  logic                    a_valid_r, a_valid_nxt;
  logic signed [ACC_W-1:0] a_s_r, a_s_nxt;
  logic [15:0]             a_idx_r, a_idx_nxt;
  logic                    a_last_r, a_last_nxt;
  logic                    a_done_r, a_done_nxt;
  logic [2:0]              a_err_r, a_err_nxt;

  // stage B: partial products
  logic               b_valid_r;
  logic signed [55:0] b_p1_r;
  logic signed [48:0] b_p0_r;
  logic [15:0]        b_idx_r;
  logic               b_last_r;
  logic               b_done_r;
  logic [2:0]         b_err_r;

  // stage C: output register
  logic               out_valid_r;
  logic signed [63:0] out_value_r;
  logic [15:0]        out_idx_r;
  logic               out_last_r;
  logic               out_done_r;
  logic [2:0]         out_err_r;

  logic               en;
  logic               emit;
  logic [31:0]        v_sel;
  logic [ACC_W:0]     sum41;
  logic signed [ACC_W-1:0] sat40;
  logic               run_end;
  logic signed [23:0] s_hi;
  logic signed [16:0] s_lo;
  logic signed [55:0] p1_c;
  logic signed [48:0] p0_c;
  logic signed [48:0] p0_sh;
  logic signed [56:0] val_c;

  assign en    = !out_valid_r || out_ready;
  assign emit  = busy_r && en;
  assign q_pop = !busy_r && !q_empty;

  always_comb begin
    v_sel   = phase_b_r ? job_r.val_b : job_r.val_a;
    sum41   = {acc_r[ACC_W-1], acc_r} + {{(ACC_W+1-32){v_sel[31]}}, v_sel};
    if (sum41[ACC_W] != sum41[ACC_W-1]) begin
      sat40 = sum41[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat40 = sum41[ACC_W-1:0];
    end
    run_end = phase_b_r || ((rem_r == CNT_W'(1)) && !job_r.has_b);
  end

  always_comb begin
    busy_nxt    = busy_r;
    job_nxt     = job_r;
    rem_nxt     = rem_r;
    phase_b_nxt = phase_b_r;
    idx_nxt     = idx_r;
    acc_nxt     = acc_r;
    a_valid_nxt = a_valid_r;
    a_s_nxt     = a_s_r;
    a_idx_nxt   = a_idx_r;
    a_last_nxt  = a_last_r;
    a_done_nxt  = a_done_r;
    a_err_nxt   = a_err_r;

    if (q_pop) begin
      busy_nxt    = 1'b1;
      job_nxt     = q_job;
      rem_nxt     = q_job.cnt_a;
      phase_b_nxt = 1'b0;
      idx_nxt     = q_job.index;
    end

    if (en) begin
      a_valid_nxt = 1'b0;
    end

    if (emit) begin
      a_valid_nxt = 1'b1;
      a_err_nxt   = ERR_NONE;
      case (job_r.kind)
        JOB_PLAIN: begin
          a_s_nxt    = {{(ACC_W-32){job_r.val_a[31]}}, job_r.val_a};
          a_idx_nxt  = job_r.index;
          a_last_nxt = 1'b1;
          a_done_nxt = job_r.shape_end;
          busy_nxt   = 1'b0;
        end
        JOB_RUN: begin
          a_s_nxt    = sat40;
          a_idx_nxt  = idx_r;
          a_last_nxt = run_end;
          a_done_nxt = run_end && job_r.shape_end;
          acc_nxt    = (run_end && job_r.shape_end) ? '0 : sat40;
          idx_nxt    = idx_r + 16'd1;
          if (!phase_b_r) begin
            rem_nxt = rem_r - 1'b1;
            if ((rem_r == CNT_W'(1)) && job_r.has_b) begin
              phase_b_nxt = 1'b1;
            end
          end
          if (run_end) begin
            busy_nxt = 1'b0;
          end
        end
        JOB_ERR: begin
          // drop the shape: zero sample, flag and restart integration
          a_s_nxt    = '0;
          a_idx_nxt  = job_r.index;
          a_last_nxt = 1'b1;
          a_done_nxt = 1'b1;
          a_err_nxt  = job_r.err;
          acc_nxt    = '0;
          busy_nxt   = 1'b0;
        end
        default: begin
          a_valid_nxt = 1'b0;
          busy_nxt    = 1'b0;
        end
      endcase
    end

    if (cfg_clear) begin
      acc_nxt = '0;
    end
  end

  // split the 40-bit sample so each product stays within 32 by 32 bits
  always_comb begin
    s_hi  = a_s_r[ACC_W-1:16];
    s_lo  = {1'b0, a_s_r[15:0]};
    p1_c  = s_hi * cfg_scale;
    p0_c  = s_lo * cfg_scale;
    p0_sh = b_p0_r >>> 16;
    val_c = 57'(b_p1_r) + 57'(p0_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_b_r   <= 1'b0;
      acc_r       <= '0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      phase_b_r <= phase_b_nxt;
      acc_r     <= acc_nxt;
      a_valid_r <= a_valid_nxt;
      if (en) begin
        b_valid_r   <= a_valid_r;
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    rem_r    <= rem_nxt;
    idx_r    <= idx_nxt;
    a_s_r    <= a_s_nxt;
    a_idx_r  <= a_idx_nxt;
    a_last_r <= a_last_nxt;
    a_done_r <= a_done_nxt;
    a_err_r  <= a_err_nxt;
    if (en) begin
      b_p1_r      <= p1_c;
      b_p0_r      <= p0_c;
      b_idx_r     <= a_idx_r;
      b_last_r    <= a_last_r;
      b_done_r    <= a_done_r;
      b_err_r     <= a_err_r;
      out_value_r <= {{7{val_c[56]}}, val_c};
      out_idx_r   <= b_idx_r;
      out_last_r  <= b_last_r;
      out_done_r  <= b_done_r;
      out_err_r   <= b_err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_value_r;
  assign out_sample_index = out_idx_r;
  assign out_run_last     = out_last_r;
  assign out_shape_done   = out_done_r;
  assign out_error_code   = out_err_r;

`ifndef SYNTHESIS
  a_err_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && (a_err_r != ERR_NONE)) |-> ((a_s_r == '0) && a_last_r && a_done_r))
    else $error("error sample not zero or not closing the shape");

  a_run_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (job_r.kind == JOB_RUN) && !phase_b_r) |-> (rem_r != '0))
    else $error("run job active with no samples left");

  a_acc_clear_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (job_r.kind == JOB_RUN) && run_end && job_r.shape_end) |=> (acc_r == '0))
    else $error("accumulator not cleared at shape end");
`endif

endmodule

@@ src/rle_derivative_shape_decoder_top.sv @@
// Top level of the run-length shape decoder: APB registers, front end, queue, back end.
// Throughput: the back-end sequencer loads a job only while idle, then emits one sample per
//   cycle while out_ready does not stall it, and takes no new job before the last one is done.
// The front end takes a word per cycle while the 4-entry job queue has room.
// Reset: synchronous active-low rst_n clears control state; scale returns to 1.0, counts to 0.
module rle_derivative_shape_decoder_top #(
  parameter int MAX_RUN = rlds_pkg::MAX_RUN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlds_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // packed word channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_packed_word,
  // sample channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [63:0]          out_sample_value,
  output logic [15:0]                 out_sample_index,
  output logic                        out_run_last,
  output logic                        out_shape_done,
  output logic [2:0]                  out_error_code
);
  import rlds_pkg::*;

  cfg_t        cfg_r, cfg_nxt;
  logic        cfg_wr;
  logic        cfg_clear;
  logic [1:0]  reg_idx;

  logic        q_push;
  logic        q_pop;
  logic        q_empty;
  logic        q_full;
  job_t        q_wjob;
  job_t        q_rjob;

  // APB: zero-wait, write lands on the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt   = cfg_r;
    cfg_clear = 1'b0;
    if (cfg_wr) begin
      case (reg_idx)
        REG_PACKED_COUNT: begin
          cfg_nxt.packed_count = pwdata[15:0];
          cfg_clear            = 1'b1;
        end
        REG_SAMPLE_COUNT: begin
          cfg_nxt.sample_count = pwdata[15:0];
          cfg_clear            = 1'b1;
        end
        REG_SCALE: begin
          cfg_nxt.scale = pwdata;
          cfg_clear     = 1'b1;
        end
        default: begin
          // unmapped address: drop the write, keep shape state
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PACKED_COUNT: prdata = {16'd0, cfg_r.packed_count};
      REG_SAMPLE_COUNT: prdata = {16'd0, cfg_r.sample_count};
      REG_SCALE:        prdata = cfg_r.scale;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.packed_count <= '0;
      cfg_r.sample_count <= '0;
      cfg_r.scale        <= 32'sd65536;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: classify each word, predict errors, issue one job at most
  rlds_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cfg_clear (cfg_clear),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_packed_word),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_wjob)
  );

  // job queue decouples word intake from sample expansion
  rlds_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wjob),
    .pop   (q_pop),
    .rdata (q_rjob),
    .empty (q_empty),
    .full  (q_full)
  );

  // back end: expand, integrate, scale and hold each result transaction
  rlds_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_scale        (cfg_r.scale),
    .cfg_clear        (cfg_clear),
    .q_empty          (q_empty),
    .q_job            (q_rjob),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_sample_index (out_sample_index),
    .out_run_last     (out_run_last),
    .out_shape_done   (out_shape_done),
    .out_error_code   (out_error_code)
  );

endmodule

@@ test/rle_derivative_shape_decoder_top_tb.sv @@
// Self-checking testbench for the run-length shape decoder: directed shapes, then random ones.
module rle_derivative_shape_decoder_top_tb;
  import rlds_pkg::*;

  // Longest run the decoder expands from a single count word.
  localparam int RUN_CAP = MAX_RUN_DEF;
  // Q16.16 unity gain, the scale register's reset value.
  localparam logic [31:0] SCALE_ONE = 32'h0001_0000;
  // Cycles to let in-flight transactions that cause no sample leave the pipeline.
  localparam int SETTLE_CYCLES = 20;
  // Receiver hold-off used to fill the job queue and stall the input channel.
  localparam int HOLD_CYCLES = 300;
  // Hard stop for the whole run, in time units (10 per clock).
  localparam int unsigned RUN_LIMIT = 5_000_000;

  // One sample on the output channel, field for field.
  typedef struct packed {
    logic signed [63:0] value;
    logic [15:0]        index;
    logic               last;
    logic               done;
    logic [2:0]         err;
  } shape_sample_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [31:0]   in_packed_word;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [63:0]   out_sample_value;
  logic [15:0]          out_sample_index;
  logic                 out_run_last;
  logic                 out_shape_done;
  logic [2:0]           out_error_code;

  // Mirror of the configuration registers.
  logic [15:0]          cfg_packed;
  logic [15:0]          cfg_samples;
  logic signed [31:0]   cfg_scale;

  // Mirror of the shape decoding state.
  logic [31:0]          held_word;
  bit                   held_ok;
  bit                   want_count;
  logic [15:0]          words_in;
  logic [15:0]          samples_out;
  logic signed [39:0]   acc;

  shape_sample_t        pending_samples[$];   // samples still owed by the DUT, oldest first
  shape_sample_t        word_samples[$];      // samples caused by the word being decoded
  logic [31:0]          shape_words[$];       // packed words of the shape being played
  int                   count_slots[$];       // positions of count words in shape_words
  int                   shape_samples;        // decoded length of shape_words
  int                   words_sent;
  int                   errors;
  bit                   idle_en;
  bit                   hold_request;

  rle_derivative_shape_decoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_packed_word   (in_packed_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_value (out_sample_value),
    .out_sample_index (out_sample_index),
    .out_run_last     (out_run_last),
    .out_shape_done   (out_shape_done),
    .out_error_code   (out_error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic shape_sample_t make_sample(input logic signed [63:0] value,
                                                input logic [15:0] index, input logic last,
                                                input logic done, input logic [2:0] err);
    shape_sample_t s;
    s.value = value;
    s.index = index;
    s.last  = last;
    s.done  = done;
    s.err   = err;
    return s;
  endfunction

  // floor(x * scale / 2^16); the arithmetic shift of the wide product gives the floor.
  function automatic logic signed [63:0] scaled(input logic signed [39:0] x);
    logic signed [79:0] prod;
    prod = x * cfg_scale;
    prod = prod >>> 16;
    return prod[63:0];
  endfunction

  // Drop all shape state so the next word starts a new shape.
  task automatic restart_shape();
    held_word   = '0;
    held_ok     = 1'b0;
    want_count  = 1'b0;
    words_in    = '0;
    samples_out = '0;
    acc         = '0;
  endtask

  // Emit the held value once: add it to the saturating sum, scale the sum.
  task automatic add_sample(inout logic [2:0] err);
    logic signed [40:0] s;
    if (err != ERR_NONE) return;
    if (samples_out >= cfg_samples || word_samples.size() >= RUN_CAP) begin
      err = ERR_LENGTH;
      return;
    end
    s = acc + $signed(held_word);
    if (s > ACC_MAX) s = ACC_MAX;
    if (s < ACC_MIN) s = ACC_MIN;
    acc = s[39:0];
    word_samples.push_back(make_sample(scaled(acc), samples_out, 1'b0, 1'b0, ERR_NONE));
    samples_out++;
  endtask

  // Work out the samples one accepted word causes and queue them.
  task automatic decode_word(input logic [31:0] w);
    logic               last;
    logic [2:0]         err;
    logic signed [31:0] c;
    int                 rep;
    shape_sample_t      tail;
    word_samples.delete();
    err = ERR_NONE;
    if (cfg_packed == 0) return;
    last = (int'(words_in) + 1 >= int'(cfg_packed));

    // Plain shape: scale the word directly, no accumulator, no errors.
    if (cfg_packed == cfg_samples) begin
      pending_samples.push_back(make_sample(scaled($signed(w)), words_in, 1'b1, last,
                                            ERR_NONE));
      if (last) restart_shape();
      else words_in++;
      return;
    end

    if (want_count) begin
      c = w;
      if (c[23:0] != 0) begin
        err = ERR_FRAC;
      end else if (c < 0) begin
        err = ERR_RANGE;
      end else begin
        rep = int'(c[30:24]) + 2;
        if (rep > RUN_CAP) err = ERR_RANGE;
        else repeat (rep) add_sample(err);
      end
      held_ok    = 1'b0;
      want_count = 1'b0;
    end else if (held_ok && w == held_word) begin
      want_count = 1'b1;
    end else begin
      if (held_ok) add_sample(err);
      held_word = w;
      held_ok   = 1'b1;
    end

    // Close the shape: flush the held value, then check the total.
    if (err == ERR_NONE && last) begin
      if (want_count) err = ERR_TRUNC;
      else if (held_ok) add_sample(err);
      if (err == ERR_NONE && samples_out != cfg_samples) err = ERR_LENGTH;
    end

    // An error replaces everything this word would have produced.
    if (err != ERR_NONE) begin
      pending_samples.push_back(make_sample('0, samples_out, 1'b1, 1'b1, err));
      restart_shape();
      return;
    end

    if (word_samples.size() > 0) begin
      tail = word_samples[word_samples.size() - 1];
      tail.last = 1'b1;
      tail.done = last;
      word_samples[word_samples.size() - 1] = tail;
    end
    if (last) restart_shape();
    else words_in++;
    foreach (word_samples[i]) pending_samples.push_back(word_samples[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Write one register over APB: setup phase, then access phase until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PACKED_COUNT: cfg_packed  = data[15:0];
      REG_SAMPLE_COUNT: cfg_samples = data[15:0];
      REG_SCALE:        cfg_scale   = data;
      default: ;
    endcase
    // Any register write starts a fresh shape.
    restart_shape();
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one word, optionally after a short gap; leave valid high on acceptance
  // so a following word goes out back to back.
  task automatic send_word(input logic [31:0] w);
    int gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_packed_word <= w;
    do @(posedge clk); while (!in_ready);
    decode_word(w);
    words_sent++;
  endtask

  // Drop valid after the last accepted transaction.
  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every owed sample, then let word-only transactions drain.
  task automatic wait_drained();
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reconfigure for a new shape; only done once the block has gone quiet.
  task automatic program_shape(input logic [15:0] packed_n, input logic [15:0] sample_n,
                               input logic [31:0] gain);
    wait_drained();
    write_reg(REG_PACKED_COUNT, {16'h0, packed_n});
    write_reg(REG_SAMPLE_COUNT, {16'h0, sample_n});
    write_reg(REG_SCALE, gain);
  endtask

  task automatic play_shape(input int copies);
    for (int c = 0; c < copies; c++) begin
      foreach (shape_words[i]) send_word(shape_words[i]);
    end
    idle_input();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] count_word(input int n);
    return 32'(n) << 24;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return count_word($urandom_range(0, 255));
      3: return 32'($urandom_range(0, 65535)) - 32'd32768;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return SCALE_ONE;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_0000;
      4: return 32'h0;
      5: return 32'($urandom_range(0, 32'h3_FFFF));
      default: return $urandom();
    endcase
  endfunction

  // Build a well-formed shape of single values and (value, value, count) runs.
  // A single never equals the word after it, so no accidental pair appears.
  task automatic compose_shape(input int segs, input int max_count);
    logic [31:0] v;
    logic [31:0] prev;
    int          cnt;
    bit          prev_single;
    shape_words.delete();
    count_slots.delete();
    shape_samples = 0;
    prev_single   = 1'b0;
    prev          = '0;
    for (int k = 0; k < segs; k++) begin
      v = pick_value();
      while (prev_single && v == prev) v = pick_value();
      if ($urandom_range(0, 1) == 1) begin
        cnt = $urandom_range(0, max_count);
        shape_words.push_back(v);
        shape_words.push_back(v);
        count_slots.push_back(shape_words.size());
        shape_words.push_back(count_word(cnt));
        shape_samples += cnt + 2;
        prev_single = 1'b0;
      end else begin
        shape_words.push_back(v);
        shape_samples++;
        prev_single = 1'b1;
        prev = v;
      end
    end
  endtask

  task automatic run_clean_shape();
    compose_shape($urandom_range(1, 5), ($urandom_range(0, 7) == 0) ? RUN_CAP - 2 : 6);
    program_shape(shape_words.size(), shape_samples, pick_scale());
    play_shape($urandom_range(1, 2));
  endtask

  task automatic run_plain_shape();
    int n;
    n = $urandom_range(1, 6);
    shape_words.delete();
    repeat (n) shape_words.push_back(pick_value());
    program_shape(n, n, pick_scale());
    play_shape($urandom_range(1, 2));
  endtask

  // Corrupt one count word, or end the shape on a pair with no count.
  task automatic run_broken_shape();
    int          pick;
    int          slot;
    logic [31:0] v;
    compose_shape($urandom_range(1, 4), 6);
    pick = $urandom_range(0, 3);
    if (pick == 3 || count_slots.size() == 0) begin
      v = pick_value();
      while (v == shape_words[shape_words.size() - 1]) v = pick_value();
      shape_words.push_back(v);
      shape_words.push_back(v);
    end else begin
      slot = count_slots[$urandom_range(0, count_slots.size() - 1)];
      case (pick)
        0: shape_words[slot] = shape_words[slot] | 32'($urandom_range(1, 24'hFF_FFFF));
        1: shape_words[slot] = shape_words[slot] | 32'h8000_0000 | $urandom();
        default: shape_words[slot] = count_word($urandom_range(RUN_CAP - 1, 127));
      endcase
    end
    program_shape(shape_words.size(), shape_samples, pick_scale());
    play_shape($urandom_range(1, 2));
  endtask

  // Well-formed words, but the declared sample total is one off.
  task automatic run_miscounted_shape();
    int n;
    compose_shape($urandom_range(1, 4), 6);
    n = ($urandom_range(0, 1) == 1 || shape_samples == 0) ? shape_samples + 1
                                                          : shape_samples - 1;
    program_shape(shape_words.size(), n, pick_scale());
    play_shape(1);
  endtask

  // Words from a tiny alphabet so pairs, counts and junk mix freely.
  task automatic run_noise_shape();
    logic [31:0] pool[4];
    int          n;
    pool[0] = pick_value();
    pool[1] = pick_value();
    pool[2] = count_word($urandom_range(0, 5));
    pool[3] = $urandom();
    n = $urandom_range(2, 10);
    shape_words.delete();
    repeat (n) shape_words.push_back(pool[$urandom_range(0, 3)]);
    program_shape(n, $urandom_range(0, 2 * n + 4), pick_scale());
    play_shape(1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // With packed_count at reset every word is ignored; scale resets to unity.
  task automatic test_reset_defaults();
    shape_words = '{32'h1234_5678};
    play_shape(1);
    wait_drained();
    write_reg(REG_PACKED_COUNT, 32'd2);
    write_reg(REG_SAMPLE_COUNT, 32'd2);
    shape_words = '{32'h7FFF_FFFF, 32'h8000_0000};
    play_shape(1);
  endtask

  task automatic test_plain_extremes();
    program_shape(2, 2, 32'h7FFF_FFFF);
    shape_words = '{32'h7FFF_FFFF, 32'h8000_0000};
    play_shape(1);
    program_shape(2, 2, 32'h8000_0000);
    shape_words = '{32'hFFFF_FFFF, 32'h8000_0000};
    play_shape(1);
  endtask

  // A run of five, a run of two (count zero), then a closing single.
  task automatic test_run_decode();
    program_shape(7, 8, SCALE_ONE);
    shape_words = '{32'h0180_0000, 32'h0180_0000, count_word(3),
                    32'hFF40_0000, 32'hFF40_0000, count_word(0), 32'h0000_0001};
    play_shape(1);
    // longest legal run
    program_shape(3, RUN_CAP, 32'hFFFF_8000);
    shape_words = '{32'h0A00_0000, 32'h0A00_0000, count_word(RUN_CAP - 2)};
    play_shape(1);
  endtask

  // Fractional count, negative count, count past the cap; each aborts its shape.
  task automatic test_count_errors();
    program_shape(9, 100, SCALE_ONE);
    shape_words = '{32'h0100_0000, 32'h0100_0000, 32'h0100_0001,
                    32'h0200_0000, 32'h0200_0000, 32'hFF00_0000,
                    32'h0300_0000, 32'h0300_0000, count_word(RUN_CAP - 1)};
    play_shape(1);
  endtask

  task automatic test_shape_length_errors();
    // pair left without its count at the end of the shape
    program_shape(2, 5, SCALE_ONE);
    shape_words = '{32'h0500_0000, 32'h0500_0000};
    play_shape(1);
    // more samples than declared
    program_shape(3, 1, SCALE_ONE);
    shape_words = '{32'h0100_0000, 32'h0200_0000, 32'h0300_0000};
    play_shape(1);
    // fewer samples than declared
    program_shape(2, 10, SCALE_ONE);
    shape_words = '{32'h0100_0000, 32'h0200_0000};
    play_shape(1);
  endtask

  task automatic test_register_extremes();
    program_shape(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
    shape_words = '{$urandom(), 32'h7FFF_FFFF, 32'h8000_0000};
    play_shape(1);
    program_shape(16'hFFFF, 16'h0, 32'h8000_0000);
    shape_words = '{32'h0100_0000, 32'h0200_0000};
    play_shape(1);
    program_shape(16'h1, 16'hFFFF, SCALE_ONE);
    shape_words = '{$urandom()};
    play_shape(1);
  endtask

  // Five full-length runs of the extreme words drive the sum into both rails.
  task automatic test_accumulator_saturation();
    program_shape(15, 5 * RUN_CAP, SCALE_ONE);
    shape_words.delete();
    repeat (5) begin
      shape_words.push_back(32'h7FFF_FFFF);
      shape_words.push_back(32'h7FFF_FFFF);
      shape_words.push_back(count_word(RUN_CAP - 2));
    end
    play_shape(1);
    program_shape(15, 5 * RUN_CAP, 32'h7FFF_FFFF);
    shape_words.delete();
    repeat (5) begin
      shape_words.push_back(32'h8000_0000);
      shape_words.push_back(32'h8000_0000);
      shape_words.push_back(count_word(RUN_CAP - 2));
    end
    play_shape(1);
  endtask

  // Hold the receiver off while long runs keep coming, so the job queue fills
  // and in_ready drops; then pause the sender mid-shape until all samples land.
  task automatic test_backpressure();
    logic [31:0] v;
    shape_words.delete();
    repeat (4) begin
      v = $urandom();
      shape_words.push_back(v);
      shape_words.push_back(v);
      shape_words.push_back(count_word(RUN_CAP - 2));
    end
    program_shape(12, 4 * RUN_CAP, pick_scale());
    hold_request = 1'b1;
    play_shape(2);

    program_shape(12, 4 * RUN_CAP, pick_scale());
    for (int k = 0; k < 6; k++) send_word(shape_words[k]);
    idle_input();
    while (pending_samples.size() != 0) @(posedge clk);
    for (int k = 6; k < 12; k++) send_word(shape_words[k]);
    idle_input();
  endtask

  // Mostly well-formed shapes with random content; the rest broken, miscounted or noise.
  task automatic test_random_shapes(input int target);
    while (words_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: run_clean_shape();
        5:             run_plain_shape();
        6, 7:          run_broken_shape();
        8:             run_miscounted_shape();
        default:       run_noise_shape();
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence, checking, receiver, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    int waited;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    in_packed_word = '0;
    idle_en        = 1'b1;
    hold_request   = 1'b0;
    errors         = 0;
    words_sent     = 0;
    cfg_packed     = '0;
    cfg_samples    = '0;
    cfg_scale      = SCALE_ONE;
    restart_shape();

    // Hold reset, then release it away from the sampling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_plain_extremes();
    test_run_decode();
    test_count_errors();
    test_shape_length_errors();
    test_register_extremes();
    test_accumulator_saturation();
    test_backpressure();
    test_random_shapes(230);
    // Run the tail with both sides streaming at full rate.
    idle_en = 1'b0;
    test_random_shapes(words_sent + 40);

    waited = 0;
    while (pending_samples.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_samples.size() != 0) begin
      $error("%0d expected samples never arrived", pending_samples.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Compare every accepted sample against the oldest expectation.
  always @(posedge clk) begin
    shape_sample_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected sample: value %0d index %0d error_code %0d",
               out_sample_value, out_sample_index, out_error_code);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        if (out_sample_value !== want.value) begin
          $error("sample_value: expected %0d, actual %0d", $signed(want.value),
                 out_sample_value);
          errors++;
        end
        if (out_sample_index !== want.index) begin
          $error("sample_index: expected %0d, actual %0d", want.index, out_sample_index);
          errors++;
        end
        if (out_run_last !== want.last) begin
          $error("run_last: expected %0d, actual %0d", want.last, out_run_last);
          errors++;
        end
        if (out_shape_done !== want.done) begin
          $error("shape_done: expected %0d, actual %0d", want.done, out_shape_done);
          errors++;
        end
        if (out_error_code !== want.err) begin
          $error("error_code: expected %0d, actual %0d", want.err, out_error_code);
          errors++;
        end
      end
    end
  end

  // Receiver: random short stalls, plus one long hold-off on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end else if (stall == 0 && idle_en && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 3);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: stop a hung run.
  initial begin
    #RUN_LIMIT;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
